// File: hdl/tsmp_pkg.sv
// Shared types, constants and helpers for the three-sensor motion poller.
`default_nettype none
package tsmp_pkg;

  localparam int NUM_SENSORS = 3;
  localparam int COUNT_WIDTH = 16;
  localparam int REPORT_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_EXPECTED_ID = 3'd0,
    CFG_HALF_BIT    = 3'd1,
    CFG_TURNAROUND  = 3'd2,
    CFG_RESYNC_WAIT = 3'd3,
    CFG_POLL_GAP    = 3'd4
  } cfg_index_t;

  // Sensor register reads that make up one poll
  typedef enum logic [1:0] {
    OP_ID     = 2'd0,
    OP_MOTION = 2'd1,
    OP_DY     = 2'd2,
    OP_DX     = 2'd3
  } op_t;

  // Sequencer steps, one-hot
  typedef enum logic [9:0] {
    ST_RS_HIGH      = 10'b00_0000_0001,
    ST_RS_LOW       = 10'b00_0000_0010,
    ST_RS_WAIT      = 10'b00_0000_0100,
    ST_WRITE1       = 10'b00_0000_1000,
    ST_WRITE2       = 10'b00_0001_0000,
    ST_ADDR         = 10'b00_0010_0000,
    ST_TURN_DRIVE   = 10'b00_0100_0000,
    ST_TURN_RELEASE = 10'b00_1000_0000,
    ST_READ         = 10'b01_0000_0000,
    ST_GAP          = 10'b10_0000_0000
  } step_t;

  localparam logic [7:0] WRITE_FLAG   = 8'h80;
  localparam logic [7:0] WRITE1_ADDR  = 8'h85;
  localparam logic [7:0] WRITE1_DATA  = 8'h21;
  localparam logic [7:0] WRITE2_ADDR  = 8'h86;
  localparam logic [7:0] WRITE2_DATA  = 8'h06;
  localparam logic [15:0] WRITE1_WORD = {WRITE1_ADDR | WRITE_FLAG, WRITE1_DATA};
  localparam logic [15:0] WRITE2_WORD = {WRITE2_ADDR | WRITE_FLAG, WRITE2_DATA};

  localparam logic [7:0] RST_EXPECTED_ID = 8'h31;
  localparam logic [7:0] RST_HALF_BIT    = 8'd5;
  localparam logic [7:0] RST_TURNAROUND  = 8'd2;
  localparam logic [15:0] RST_RESYNC     = 16'd5000;
  localparam logic [15:0] RST_POLL_GAP   = 16'd1000;

  typedef struct packed {
    logic [7:0]  expected_id;
    logic [7:0]  half_bit_ticks;
    logic [7:0]  turnaround_ticks;
    logic [15:0] resync_wait_ticks;
    logic [15:0] poll_gap_ticks;
  } cfg_t;

  // Line levels for one tick
  typedef struct packed {
    logic clk_level;
    logic data_level;
    logic data_drive;
  } line_t;

  // Accumulate request from the sequencer to the counters
  typedef struct packed {
    logic                        add;
    logic [NUM_SENSORS-1:0][7:0] dx;
    logic [NUM_SENSORS-1:0][7:0] dy;
  } acc_req_t;

  typedef logic signed [2*NUM_SENSORS-1:0][COUNT_WIDTH-1:0] counts_t;

  function automatic logic [7:0] read_addr(input op_t op);
    logic [7:0] a;
    case (op)
      OP_ID:     a = 8'h00;
      OP_MOTION: a = 8'h02;
      OP_DY:     a = 8'h04;
      OP_DX:     a = 8'h03;
      default:   a = 8'h00;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: hdl/tsmp_tick_if.sv
// Tick request channel: sampled data lines and drain.
`default_nettype none
interface tsmp_tick_if import tsmp_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [NUM_SENSORS-1:0] data_pins;
  logic                   drain;

  modport source (output valid, data_pins, drain, input ready);
  modport sink   (input valid, data_pins, drain, output ready);
endinterface
`default_nettype wire

// File: hdl/tsmp_report_if.sv
// Report channel: line levels, drained counts and sync status.
`default_nettype none
interface tsmp_report_if import tsmp_pkg::*;;
  logic                            valid;
  logic                            ready;
  logic                            clk_level;
  logic                            data_level;
  logic                            data_drive;
  logic signed [REPORT_WIDTH-1:0]  first_dx;
  logic signed [REPORT_WIDTH-1:0]  first_dy;
  logic signed [REPORT_WIDTH-1:0]  second_dx;
  logic signed [REPORT_WIDTH-1:0]  second_dy;
  logic signed [REPORT_WIDTH-1:0]  third_dx;
  logic signed [REPORT_WIDTH-1:0]  third_dy;
  logic                            counts_valid;
  logic                            in_sync;

  modport source (output valid, clk_level, data_level, data_drive, first_dx, first_dy,
                  second_dx, second_dy, third_dx, third_dy, counts_valid, in_sync,
                  input ready);
  modport sink   (input valid, clk_level, data_level, data_drive, first_dx, first_dy,
                  second_dx, second_dy, third_dx, third_dy, counts_valid, in_sync,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/three_sensor_motion_poller.sv
// Top level: configuration registers, sequencer, accumulators, report register.
// The report for an accepted tick request is registered and appears in the cycle after it.
// Throughput: one tick request per cycle unless the report stalls; each tick runs a
//   single pass of the sequencer and accumulator logic into the report register.
// Reset (rst, synchronous): configuration to defaults, sequencer to the start
//   of resync, counts and sync flag cleared, report register empty.
`default_nettype none
module three_sensor_motion_poller import tsmp_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  tsmp_tick_if.sink                       tick,
  tsmp_report_if.source                   report
);

  cfg_t     cfg;
  logic     fire;
  line_t    line;
  logic     in_sync;
  acc_req_t acc;
  counts_t  counts;

  // Report register; a new request enters whenever it is empty or being taken
  logic    rpt_valid;
  line_t   rpt_line;
  counts_t rpt_counts;
  logic    rpt_drain;
  logic    rpt_sync;

  assign tick.ready = !rpt_valid || report.ready;
  assign fire       = tick.valid && tick.ready;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_id       <= RST_EXPECTED_ID;
      cfg.half_bit_ticks    <= RST_HALF_BIT;
      cfg.turnaround_ticks  <= RST_TURNAROUND;
      cfg.resync_wait_ticks <= RST_RESYNC;
      cfg.poll_gap_ticks    <= RST_POLL_GAP;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EXPECTED_ID: cfg.expected_id       <= cfg_data[7:0];
        CFG_HALF_BIT:    cfg.half_bit_ticks    <= cfg_data[7:0];
        CFG_TURNAROUND:  cfg.turnaround_ticks  <= cfg_data[7:0];
        CFG_RESYNC_WAIT: cfg.resync_wait_ticks <= cfg_data;
        CFG_POLL_GAP:    cfg.poll_gap_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  tsmp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_pins (tick.data_pins),
    .cfg       (cfg),
    .line      (line),
    .in_sync   (in_sync),
    .acc       (acc)
  );

  tsmp_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .drain  (tick.drain),
    .acc    (acc),
    .counts (counts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (fire) begin
      rpt_valid <= 1'b1;
    end else if (report.ready) begin
      rpt_valid <= 1'b0;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (fire) begin
      rpt_line   <= line;
      rpt_counts <= counts;
      rpt_drain  <= tick.drain;
      rpt_sync   <= in_sync;
    end
  end

  // Counts show only on a drain; data level reads low while released
  assign report.valid        = rpt_valid;
  assign report.clk_level    = rpt_line.clk_level;
  assign report.data_drive   = rpt_line.data_drive;
  assign report.data_level   = rpt_line.data_drive && rpt_line.data_level;
  assign report.first_dx     = rpt_drain ? REPORT_WIDTH'(rpt_counts[0]) : '0;
  assign report.first_dy     = rpt_drain ? REPORT_WIDTH'(rpt_counts[1]) : '0;
  assign report.second_dx    = rpt_drain ? REPORT_WIDTH'(rpt_counts[2]) : '0;
  assign report.second_dy    = rpt_drain ? REPORT_WIDTH'(rpt_counts[3]) : '0;
  assign report.third_dx     = rpt_drain ? REPORT_WIDTH'(rpt_counts[4]) : '0;
  assign report.third_dy     = rpt_drain ? REPORT_WIDTH'(rpt_counts[5]) : '0;
  assign report.counts_valid = rpt_drain;
  assign report.in_sync      = rpt_sync;

endmodule
`default_nettype wire

// File: hdl/tsmp_seq.sv
// Bit-bang sequencer: resync, register writes, poll reads and gap timing.
`default_nettype none
module tsmp_seq import tsmp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   fire,
  input  wire logic [NUM_SENSORS-1:0] data_pins,
  input  wire cfg_t                   cfg,
  output line_t                       line,
  output logic                        in_sync,
  output acc_req_t                    acc
);

  step_t                       state, state_next;
  op_t                         op, op_next;
  logic [15:0]                 wait_counter, wait_counter_next;
  logic [3:0]                  bit_index, bit_index_next;
  logic [15:0]                 shift_out, shift_out_next;
  logic [NUM_SENSORS-1:0][7:0] read_bytes, read_bytes_next;
  logic [NUM_SENSORS-1:0][7:0] held_dy, held_dy_next;
  logic                        sync_flag, sync_flag_next;

  logic [7:0]                  h_len, t_len;
  logic [8:0]                  bit_len;
  logic [16:0]                 cnt_inc;
  logic                        half_high, bit_end;
  logic [NUM_SENSORS-1:0][7:0] new_bytes;
  logic                        id_ok;
  logic                        go, add;
  step_t                       go_state, enter_state;
  op_t                         go_op, enter_op;

  assign h_len   = (cfg.half_bit_ticks == 8'd0) ? 8'd1 : cfg.half_bit_ticks;
  assign t_len   = (cfg.turnaround_ticks == 8'd0) ? 8'd1 : cfg.turnaround_ticks;
  assign bit_len = {h_len, 1'b0};
  assign cnt_inc = {1'b0, wait_counter} + 17'd1;
  assign half_high = wait_counter >= {8'd0, h_len};
  assign bit_end   = cnt_inc >= {8'd0, bit_len};

  always_comb begin
    id_ok = 1'b1;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      new_bytes[k] = {read_bytes[k][6:0], data_pins[k]};
      if (new_bytes[k] != cfg.expected_id) id_ok = 1'b0;
    end
  end

  always_comb begin
    state_next        = state;
    op_next           = op;
    wait_counter_next = wait_counter;
    bit_index_next    = bit_index;
    shift_out_next    = shift_out;
    read_bytes_next   = read_bytes;
    held_dy_next      = held_dy;
    sync_flag_next    = sync_flag;
    line              = '{clk_level: 1'b1, data_level: 1'b0, data_drive: 1'b0};
    go                = 1'b0;
    go_state          = state;
    go_op             = op;
    add               = 1'b0;

    case (state)
      ST_RS_HIGH: begin
        if (cnt_inc >= {9'd0, h_len}) begin
          go = 1'b1;
          go_state = ST_RS_LOW;
        end else begin
          wait_counter_next = cnt_inc[15:0];
        end
      end
      ST_RS_LOW: begin
        line.clk_level = 1'b0;
        if (cnt_inc >= {9'd0, t_len}) begin
          go = 1'b1;
          go_state = ST_RS_WAIT;
        end else begin
          wait_counter_next = cnt_inc[15:0];
        end
      end
      ST_RS_WAIT: begin
        if (cnt_inc >= {1'b0, cfg.resync_wait_ticks}) begin
          go = 1'b1;
          go_state = ST_WRITE1;
        end else begin
          wait_counter_next = cnt_inc[15:0];
        end
      end
      ST_WRITE1, ST_WRITE2, ST_ADDR: begin
        line.clk_level  = half_high;
        line.data_level = shift_out[15];
        line.data_drive = 1'b1;
        if (bit_end) begin
          shift_out_next    = {shift_out[14:0], 1'b0};
          wait_counter_next = '0;
          if ((state == ST_ADDR) ? (bit_index >= 4'd7) : (bit_index == 4'd15)) begin
            go = 1'b1;
            case (state)
              ST_WRITE1: go_state = ST_WRITE2;
              ST_WRITE2: begin
                go_state = ST_ADDR;
                go_op    = OP_ID;
              end
              default:   go_state = ST_TURN_DRIVE;
            endcase
          end else begin
            bit_index_next = bit_index + 4'd1;
          end
        end else begin
          wait_counter_next = cnt_inc[15:0];
        end
      end
      ST_TURN_DRIVE, ST_TURN_RELEASE: begin
        line.data_drive = (state == ST_TURN_DRIVE);
        if (cnt_inc >= {9'd0, t_len}) begin
          go = 1'b1;
          go_state = (state == ST_TURN_DRIVE) ? ST_TURN_RELEASE : ST_READ;
        end else begin
          wait_counter_next = cnt_inc[15:0];
        end
      end
      ST_READ: begin
        line.clk_level = half_high;
        if (bit_end) begin
          read_bytes_next   = new_bytes;
          wait_counter_next = '0;
          if (bit_index >= 4'd7) begin
            go = 1'b1;
            case (op)
              OP_ID: begin
                sync_flag_next = id_ok;
                go_state = id_ok ? ST_ADDR : ST_RS_HIGH;
                go_op    = OP_MOTION;
              end
              OP_MOTION: begin
                go_state = ST_ADDR;
                go_op    = OP_DY;
              end
              OP_DY: begin
                held_dy_next = new_bytes;
                go_state = ST_ADDR;
                go_op    = OP_DX;
              end
              default: begin
                add      = 1'b1;
                go_state = ST_GAP;
              end
            endcase
          end else begin
            bit_index_next = bit_index + 4'd1;
          end
        end else begin
          wait_counter_next = cnt_inc[15:0];
        end
      end
      ST_GAP: begin
        if (cnt_inc >= {1'b0, cfg.poll_gap_ticks}) begin
          go = 1'b1;
          go_state = ST_ADDR;
          go_op    = OP_ID;
        end else begin
          wait_counter_next = cnt_inc[15:0];
        end
      end
      default: begin
        go = 1'b1;
        go_state = ST_RS_HIGH;
      end
    endcase

    // Entering a step; zero-length resync and poll-gap waits fall straight through
    enter_state = go_state;
    enter_op    = go_op;
    if (go_state == ST_RS_WAIT && cfg.resync_wait_ticks == 16'd0) enter_state = ST_WRITE1;
    if (go_state == ST_GAP && cfg.poll_gap_ticks == 16'd0) begin
      enter_state = ST_ADDR;
      enter_op    = OP_ID;
    end
    if (go) begin
      state_next        = enter_state;
      op_next           = enter_op;
      wait_counter_next = '0;
      bit_index_next    = '0;
      case (enter_state)
        ST_WRITE1: shift_out_next = WRITE1_WORD;
        ST_WRITE2: shift_out_next = WRITE2_WORD;
        ST_ADDR: begin
          shift_out_next  = {read_addr(enter_op), 8'h00};
          read_bytes_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RS_HIGH;
      op           <= OP_ID;
      wait_counter <= '0;
      bit_index    <= '0;
      shift_out    <= '0;
      read_bytes   <= '0;
      held_dy      <= '0;
      sync_flag    <= 1'b0;
    end else if (fire) begin
      state        <= state_next;
      op           <= op_next;
      wait_counter <= wait_counter_next;
      bit_index    <= bit_index_next;
      shift_out    <= shift_out_next;
      read_bytes   <= read_bytes_next;
      held_dy      <= held_dy_next;
      sync_flag    <= sync_flag_next;
    end
  end

  assign in_sync = sync_flag_next;
  assign acc.add = fire && add;
  assign acc.dx  = new_bytes;
  assign acc.dy  = held_dy;

`ifndef SYNTHESIS
  a_bit_in_byte: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADDR || state == ST_READ) |-> bit_index <= 4'd7)
    else $error("bit index past byte end");
  a_add_then_gap: assert property (@(posedge clk) disable iff (rst)
    acc.add |=> (state == ST_GAP || (state == ST_ADDR && op == OP_ID)))
    else $error("accumulate not followed by gap or new poll");
  a_resync_clears_sync: assert property (@(posedge clk) disable iff (rst)
    (fire && state == ST_READ && state_next == ST_RS_HIGH) |=> !sync_flag)
    else $error("resync entered while still flagged in sync");
`endif

endmodule
`default_nettype wire

// File: hdl/tsmp_accum.sv
// Saturating motion accumulators with drain-and-clear.
`default_nettype none
module tsmp_accum import tsmp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire logic     drain,
  input  wire acc_req_t acc,
  output counts_t       counts
);

  counts_t count_store;

  function automatic logic signed [COUNT_WIDTH-1:0] sat_add(
    input logic signed [COUNT_WIDTH-1:0] a, input logic [7:0] b);
    logic signed [COUNT_WIDTH:0] sum;
    sum = {a[COUNT_WIDTH-1], a} + {{(COUNT_WIDTH-7){b[7]}}, b};
    if (sum[COUNT_WIDTH] != sum[COUNT_WIDTH-1])
      return sum[COUNT_WIDTH] ? {1'b1, {(COUNT_WIDTH-1){1'b0}}}
                              : {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    return sum[COUNT_WIDTH-1:0];
  endfunction

  // Counts after this tick's accumulate, so a drain sees them
  always_comb begin
    counts = count_store;
    if (acc.add) begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
        counts[2*k]   = sat_add(count_store[2*k], acc.dx[k]);
        counts[2*k+1] = sat_add(count_store[2*k+1], acc.dy[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_store <= '0;
    end else if (fire) begin
      count_store <= drain ? '0 : counts;
    end
  end

endmodule
`default_nettype wire
